// ----- sv/fpsq_pkg.sv -----
package fpsq_pkg;

  localparam int FRAC_W     = 5;
  localparam int FRAC_RESET = 15;
  localparam int ROOT_W     = 16;

  typedef struct packed {
    logic valid;
    logic load;
  } fpsq_ctl_t;

endpackage

// ----- sv/fpsq_if.sv -----
interface fpsq_in_if #(
  parameter int DATA_WIDTH = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface fpsq_out_if ();
  logic                        valid;
  logic                        ready;
  logic [fpsq_pkg::ROOT_W-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink (input valid, input root, output ready);
endinterface

// ----- sv/fpsq_cfg.sv -----
module fpsq_cfg #(
  parameter int DATA_WIDTH = 16,
  localparam int IW = $clog2(DATA_WIDTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fpsq_pkg::FRAC_W-1:0] cfg_data,
  output logic [IW-1:0]               iters
);

  localparam int CW = (IW > fpsq_pkg::FRAC_W) ? IW : fpsq_pkg::FRAC_W;

  logic [IW-1:0] iters_r;
  logic [IW-1:0] iters_nxt;

  function automatic logic [IW-1:0] iters_of(input logic [fpsq_pkg::FRAC_W-1:0] fb);
    logic [CW-1:0] fb_ext;
    logic [CW-1:0] fb_sat;
    logic [CW-1:0] cnt;
    fb_ext = CW'(fb);
    fb_sat = (fb_ext > CW'(DATA_WIDTH)) ? CW'(DATA_WIDTH) : fb_ext;
    cnt    = CW'(DATA_WIDTH / 2) + ((CW'(DATA_WIDTH) - fb_sat) >> 1);
    return cnt[IW-1:0];
  endfunction

  always_comb begin
    iters_nxt = iters_r;
    if (cfg_we) begin
      iters_nxt = iters_of(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iters_r <= iters_of(fpsq_pkg::FRAC_W'(fpsq_pkg::FRAC_RESET));
    end else begin
      iters_r <= iters_nxt;
    end
  end

  assign iters = iters_r;

endmodule

// ----- sv/fpsq_stage.sv -----
module fpsq_stage #(
  parameter int DATA_WIDTH = 16,
  parameter int IDX = 0,
  localparam int IW = $clog2(DATA_WIDTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fpsq_pkg::fpsq_ctl_t   ctl,
  input  logic [IW-1:0]         iters,
  input  logic [DATA_WIDTH-1:0] src_i,
  input  logic [DATA_WIDTH+1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] rt_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] src_o,
  output logic [DATA_WIDTH+1:0] rem_o,
  output logic [DATA_WIDTH-1:0] rt_o
);

  logic                  valid_r;
  logic [DATA_WIDTH-1:0] src_r;
  logic [DATA_WIDTH+1:0] rem_r;
  logic [DATA_WIDTH-1:0] rt_r;
  logic [DATA_WIDTH-1:0] src_nxt;
  logic [DATA_WIDTH+1:0] rem_nxt;
  logic [DATA_WIDTH-1:0] rt_nxt;
  logic [DATA_WIDTH+1:0] rem_sh;
  logic [DATA_WIDTH+1:0] trial;
  logic                  active;
  logic                  ge;

  always_comb begin
    active = IW'(IDX) < iters;
    rem_sh = {rem_i[DATA_WIDTH-1:0], src_i[DATA_WIDTH-1:DATA_WIDTH-2]};
    trial  = {rt_i, 2'b01};
    ge     = rem_sh >= trial;
    if (active) begin
      src_nxt = {src_i[DATA_WIDTH-3:0], 2'b00};
      rem_nxt = ge ? (rem_sh - trial) : rem_sh;
      rt_nxt  = {rt_i[DATA_WIDTH-2:0], ge};
    end else begin
      src_nxt = src_i;
      rem_nxt = rem_i;
      rt_nxt  = rt_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      src_r <= src_nxt;
      rem_r <= rem_nxt;
      rt_r  <= rt_nxt;
    end
  end

  assign valid_o = valid_r;
  assign src_o   = src_r;
  assign rem_o   = rem_r;
  assign rt_o    = rt_r;

endmodule

// ----- sv/fixed_point_square_root_top.sv -----
// Restoring square root, one result bit per active stage of DATA_WIDTH stages;
// every beat is registered in each stage; stages past the iteration count set
// by frac_bits only carry the data along. A new beat is taken every cycle
// unless the pipe is full and the output stalls. Each stage holds its beat
// until the next one frees up, so a stalled output fills bubbles before the
// input side backs up. The user must write frac_bits via cfg_we/cfg_data only
// while the pipe is empty, unenforced by the block; it applies to the next beat.
module fixed_point_square_root_top #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fpsq_pkg::FRAC_W-1:0] cfg_data,
  fpsq_in_if.sink                     in_chan,
  fpsq_out_if.source                  out_chan
);

  localparam int IW = $clog2(DATA_WIDTH + 1);

  logic [IW-1:0]         iters;
  logic                  rdy   [DATA_WIDTH+1];
  logic                  v_w   [DATA_WIDTH];
  logic [DATA_WIDTH-1:0] src_w [DATA_WIDTH];
  logic [DATA_WIDTH+1:0] rem_w [DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rt_w  [DATA_WIDTH];

  fpsq_cfg #(.DATA_WIDTH(DATA_WIDTH)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .iters    (iters)
  );

  assign rdy[DATA_WIDTH] = out_chan.ready;

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
    fpsq_pkg::fpsq_ctl_t   ctl;
    logic [DATA_WIDTH-1:0] src_in;
    logic [DATA_WIDTH+1:0] rem_in;
    logic [DATA_WIDTH-1:0] rt_in;

    assign rdy[k] = !v_w[k] || rdy[k+1];

    if (k == 0) begin : g_first
      assign ctl.valid = in_chan.valid;
      assign src_in    = in_chan.value;
      assign rem_in    = '0;
      assign rt_in     = '0;
    end else begin : g_next
      assign ctl.valid = v_w[k-1];
      assign src_in    = src_w[k-1];
      assign rem_in    = rem_w[k-1];
      assign rt_in     = rt_w[k-1];
    end
    assign ctl.load = rdy[k];

    fpsq_stage #(.DATA_WIDTH(DATA_WIDTH), .IDX(k)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .iters   (iters),
      .src_i   (src_in),
      .rem_i   (rem_in),
      .rt_i    (rt_in),
      .valid_o (v_w[k]),
      .src_o   (src_w[k]),
      .rem_o   (rem_w[k]),
      .rt_o    (rt_w[k])
    );
  end

  assign in_chan.ready  = rdy[0];
  assign out_chan.valid = v_w[DATA_WIDTH-1];

  if (DATA_WIDTH >= fpsq_pkg::ROOT_W) begin : g_root_cut
    assign out_chan.root = rt_w[DATA_WIDTH-1][fpsq_pkg::ROOT_W-1:0];
  end else begin : g_root_ext
    assign out_chan.root = fpsq_pkg::ROOT_W'(rt_w[DATA_WIDTH-1]);
  end

  // a ready sink frees every stage
  a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.ready |-> in_chan.ready)
    else $error("input stalled while output ready");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result beat right after reset");

  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    iters >= IW'(DATA_WIDTH / 2) && iters <= IW'(DATA_WIDTH))
    else $error("iteration count out of range");

endmodule
